@@ rtl/spq_pkg.sv @@
// shared types and codes for the stable sorted priority queue
package spq_pkg;

  // operation codes carried by the op field
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_CHG  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPORT,
    ST_ENQ_RD,
    ST_ENQ_CMP,
    ST_FRONT_RD,
    ST_FRONT,
    ST_CHG_RD,
    ST_CHG_WR
  } state_t;

endpackage

@@ rtl/stable_sorted_priority_queue.sv @@
// Stable sorted priority queue: up to DEPTH entries kept in ascending priority order in a
// circular buffer memory with one read and one write port, driven by a small sequencer
// around one priority comparator and one saturating adder. One transaction is worked at a
// time and in_stall stays high until it is done, after which out_valid rises. Each entry
// that an enqueue moves up or a change adjusts is read in one sequencer state and written
// in the next; a dequeue or peek reads the front entry, and an error or a change on an
// empty queue goes straight to the report state. Ties keep arrival order, dequeue only
// advances the head pointer, and a new transaction can be taken in the same cycle the
// previous result is taken.
module stable_sorted_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic signed [PRIO_WIDTH-1:0]     new_priority,
  input  logic [DATA_WIDTH-1:0]            new_data,
  input  logic signed [PRIO_WIDTH-1:0]     delta,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic signed [PRIO_WIDTH-1:0]     front_priority,
  output logic [DATA_WIDTH-1:0]            front_data,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic                             is_empty
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic signed [PRIO_WIDTH-1:0] PRIO_MAX = {1'b0, {(PRIO_WIDTH-1){1'b1}}};
  localparam logic signed [PRIO_WIDTH-1:0] PRIO_MIN = {1'b1, {(PRIO_WIDTH-1){1'b0}}};

  // entry storage, undefined until written
  logic signed [PRIO_WIDTH-1:0] mem_prio [DEPTH];
  logic [DATA_WIDTH-1:0]        mem_data [DEPTH];

  state_t state, state_next;

  logic [AW-1:0]                head;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                idx;
  logic [1:0]                   op_q;
  logic [1:0]                   stat_q;
  logic signed [PRIO_WIDTH-1:0] prio_q;
  logic [DATA_WIDTH-1:0]        data_q;
  logic signed [PRIO_WIDTH-1:0] delta_q;
  logic signed [PRIO_WIDTH-1:0] rd_prio;
  logic [DATA_WIDTH-1:0]        rd_data;

  logic                         in_accept;
  logic                         out_accept;
  logic [1:0]                   stat_accept;

  // sequencer outputs
  logic                         finish;
  logic                         front_en;
  logic                         we_prio;
  logic                         we_data;
  logic                         wr_move;
  logic                         wr_sat;
  logic                         idx_dec;
  logic                         idx_inc;
  logic                         rd_prev;
  logic [CW-1:0]                cnt_next;
  logic [AW-1:0]                head_next;

  // address and datapath
  logic [CW-1:0]                rd_log;
  logic [SW-1:0]                rd_sum;
  logic [SW-1:0]                wr_sum;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic signed [PRIO_WIDTH:0]   sum_ext;
  logic signed [PRIO_WIDTH-1:0] sat_prio;
  logic                         moves_up;
  logic signed [PRIO_WIDTH-1:0] wr_prio;
  logic [DATA_WIDTH-1:0]        wr_data;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (state != ST_IDLE) || (out_valid && out_stall);

  // status decided at accept time
  always_comb begin
    stat_accept = STAT_OK;
    case (op) inside
      OP_ENQ:          if (cnt == DEPTH_C) stat_accept = STAT_FULL;
      OP_DEQ, OP_PEEK: if (cnt == '0) stat_accept = STAT_EMPTY;
      default:         stat_accept = STAT_OK;
    endcase
  end

  // circular buffer addressing, logical slot plus head modulo depth
  assign rd_log  = rd_prev ? (idx - CW'(1)) : idx;
  assign rd_sum  = SW'(head) + SW'(rd_log);
  assign wr_sum  = SW'(head) + SW'(idx);
  assign rd_addr = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : rd_sum[AW-1:0];
  assign wr_addr = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : wr_sum[AW-1:0];

  // shared comparator and saturating adder
  assign moves_up = rd_prio > prio_q;
  assign sum_ext  = {rd_prio[PRIO_WIDTH-1], rd_prio} + {delta_q[PRIO_WIDTH-1], delta_q};
  always_comb begin
    if (sum_ext[PRIO_WIDTH] != sum_ext[PRIO_WIDTH-1]) begin
      sat_prio = sum_ext[PRIO_WIDTH] ? PRIO_MIN : PRIO_MAX;
    end else begin
      sat_prio = sum_ext[PRIO_WIDTH-1:0];
    end
  end

  assign wr_prio = wr_sat ? sat_prio : (wr_move ? rd_prio : prio_q);
  assign wr_data = wr_move ? rd_data : data_q;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (stat_accept != STAT_OK || (op == OP_CHG && cnt == '0)) begin
            state_next = ST_REPORT;
          end else begin
            case (op) inside
              OP_ENQ:          state_next = ST_ENQ_RD;
              OP_DEQ, OP_PEEK: state_next = ST_FRONT_RD;
              default:         state_next = ST_CHG_RD;
            endcase
          end
        end
      end
      ST_REPORT:   state_next = ST_IDLE;
      ST_ENQ_RD:   state_next = (idx == '0) ? ST_IDLE : ST_ENQ_CMP;
      ST_ENQ_CMP:  state_next = moves_up ? ST_ENQ_RD : ST_IDLE;
      ST_FRONT_RD: state_next = ST_FRONT;
      ST_FRONT:    state_next = ST_IDLE;
      ST_CHG_RD:   state_next = ST_CHG_WR;
      ST_CHG_WR:   state_next = (idx + CW'(1) == cnt) ? ST_IDLE : ST_CHG_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    finish    = 1'b0;
    front_en  = 1'b0;
    we_prio   = 1'b0;
    we_data   = 1'b0;
    wr_move   = 1'b0;
    wr_sat    = 1'b0;
    idx_dec   = 1'b0;
    idx_inc   = 1'b0;
    rd_prev   = 1'b0;
    cnt_next  = cnt;
    head_next = head;
    unique case (state)
      ST_IDLE: ;
      ST_REPORT: finish = 1'b1;
      ST_ENQ_RD: begin
        rd_prev = 1'b1;
        if (idx == '0) begin
          we_prio  = 1'b1;
          we_data  = 1'b1;
          finish   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      ST_ENQ_CMP: begin
        we_prio = 1'b1;
        we_data = 1'b1;
        if (moves_up) begin
          wr_move = 1'b1;
          idx_dec = 1'b1;
        end else begin
          finish   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      ST_FRONT_RD: ;
      ST_FRONT: begin
        finish   = 1'b1;
        front_en = 1'b1;
        if (op_q == OP_DEQ) begin
          cnt_next  = cnt - CW'(1);
          head_next = (head == LAST_A) ? '0 : head + AW'(1);
        end
      end
      ST_CHG_RD: ;
      ST_CHG_WR: begin
        we_prio = 1'b1;
        wr_sat  = 1'b1;
        idx_inc = 1'b1;
        finish  = (idx + CW'(1) == cnt);
      end
      default: ;
    endcase
  end

  // state, occupancy and head pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      head  <= head_next;
    end
  end

  // latched transaction and scan index
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q    <= op;
      prio_q  <= new_priority;
      data_q  <= new_data;
      delta_q <= delta;
      stat_q  <= stat_accept;
      idx     <= (op == OP_ENQ) ? cnt : '0;
    end else if (idx_dec) begin
      idx <= idx - CW'(1);
    end else if (idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we_prio) mem_prio[wr_addr] <= wr_prio;
    if (we_data) mem_data[wr_addr] <= wr_data;
    rd_prio <= mem_prio[rd_addr];
    rd_data <= mem_data[rd_addr];
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (finish) begin
      status         <= stat_q;
      front_priority <= front_en ? rd_prio : '0;
      front_data     <= front_en ? rd_data : '0;
      count          <= cnt_next;
      is_empty       <= (cnt_next == '0);
    end
  end

endmodule

@@ tb/spq_checker.sv @@
// checker for the stable sorted priority queue: watches both channels, predicts and compares
`timescale 1ns / 100ps

module spq_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic signed [PRIO_WIDTH-1:0] new_priority,
  input  logic [DATA_WIDTH-1:0]        new_data,
  input  logic signed [PRIO_WIDTH-1:0] delta,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   status,
  input  logic signed [PRIO_WIDTH-1:0] front_priority,
  input  logic [DATA_WIDTH-1:0]        front_data,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic                         is_empty,
  output int                           fail_count,
  output int                           pending
);
  import spq_pkg::*;

  localparam int     CW      = $clog2(DEPTH + 1);
  localparam longint PRIO_HI = (longint'(1) << (PRIO_WIDTH - 1)) - 1;
  localparam longint PRIO_LO = -PRIO_HI - 1;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0]        data;
    logic [CW-1:0]                count;
    logic                         is_empty;
  } queue_result_t;

  // shadow copy of the stored entries, kept sorted by priority
  logic signed [PRIO_WIDTH-1:0] held_prio [DEPTH];
  logic [DATA_WIDTH-1:0]        held_data [DEPTH];
  int                           held_count = 0;

  queue_result_t awaited_results[$];
  queue_result_t got;
  queue_result_t want;
  int            mismatches = 0;

  // priority plus delta, clamped to the signed priority range
  function automatic logic signed [PRIO_WIDTH-1:0] clamp_add(
    input logic signed [PRIO_WIDTH-1:0] a,
    input logic signed [PRIO_WIDTH-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > PRIO_HI) return PRIO_WIDTH'(PRIO_HI);
    if (s < PRIO_LO) return PRIO_WIDTH'(PRIO_LO);
    return PRIO_WIDTH'(s);
  endfunction

  // apply one operation to the shadow queue and return the result it gives
  function automatic queue_result_t apply_queue_op(
    input logic [1:0]                   o,
    input logic signed [PRIO_WIDTH-1:0] p,
    input logic [DATA_WIDTH-1:0]        d,
    input logic signed [PRIO_WIDTH-1:0] dl
  );
    queue_result_t r;
    int            pos;
    int            i;
    r = '0;
    r.status = STAT_OK;
    case (o) inside
      OP_ENQ: begin
        if (held_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // insert behind every entry of equal priority
          pos = 0;
          while (pos < held_count && held_prio[pos] <= p) pos++;
          for (i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_data[i] = held_data[i-1];
          end
          held_prio[pos] = p;
          held_data[pos] = d;
          held_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (held_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.prio = held_prio[0];
          r.data = held_data[0];
          if (o == OP_DEQ) begin
            for (i = 1; i < held_count; i++) begin
              held_prio[i-1] = held_prio[i];
              held_data[i-1] = held_data[i];
            end
            held_count--;
          end
        end
      end
      default: begin
        for (i = 0; i < held_count; i++) held_prio[i] = clamp_add(held_prio[i], dl);
      end
    endcase
    r.count    = CW'(held_count);
    r.is_empty = (held_count == 0);
    return r;
  endfunction

  // compare results in order, then predict the transaction taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      awaited_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status   = status;
        got.prio     = front_priority;
        got.data     = front_data;
        got.count    = count;
        got.is_empty = is_empty;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result: status %0d prio %0d data %h count %0d empty %0b",
                     $realtime, got.status, got.prio, got.data, got.count, got.is_empty);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: expected status %0d prio %0d data %h count %0d empty %0b",
                       $realtime, want.status, want.prio, want.data, want.count, want.is_empty);
              $display("%0t: actual   status %0d prio %0d data %h count %0d empty %0b",
                       $realtime, got.status, got.prio, got.data, got.count, got.is_empty);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_queue_op(op, new_priority, new_data, delta));
      pending <= awaited_results.size();
    end
    fail_count <= mismatches;
  end

endmodule

@@ tb/tb_stable_sorted_priority_queue.sv @@
// testbench top for the stable sorted priority queue: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_stable_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1925;
  // priorities used to fill the queue in the directed part
  localparam logic [16*16-1:0] FILL_PRIO = {
    16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h0005,
    16'h0005, 16'hfffb, 16'h7fff, 16'h8000, 16'h0064, 16'hff9c, 16'h0000, 16'h0007
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         op;
  logic signed [15:0] new_priority;
  logic [31:0]        new_data;
  logic signed [15:0] delta;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic signed [15:0] front_priority;
  logic [31:0]        front_data;
  logic [4:0]         count;
  logic               is_empty;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit in_quiet    = 0;
  bit rx_quiet    = 0;
  bit hold_rx     = 0;

  stable_sorted_priority_queue #(
    .DEPTH(16), .DATA_WIDTH(32), .PRIO_WIDTH(16)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .new_priority(new_priority),
    .new_data(new_data), .delta(delta),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .front_priority(front_priority), .front_data(front_data), .count(count),
    .is_empty(is_empty)
  );

  spq_checker #(
    .DEPTH(16), .DATA_WIDTH(32), .PRIO_WIDTH(16)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .new_priority(new_priority),
    .new_data(new_data), .delta(delta),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .front_priority(front_priority), .front_data(front_data), .count(count),
    .is_empty(is_empty), .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // operation mix by phase: 0 fills, 1 drains, others balanced
  function automatic logic [1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 65) return OP_ENQ;
        if (r < 80) return OP_DEQ;
        if (r < 90) return OP_PEEK;
        return OP_CHG;
      end
      1: begin
        if (r < 15) return OP_ENQ;
        if (r < 80) return OP_DEQ;
        if (r < 90) return OP_PEEK;
        return OP_CHG;
      end
      default: begin
        if (r < 38) return OP_ENQ;
        if (r < 72) return OP_DEQ;
        if (r < 86) return OP_PEEK;
        return OP_CHG;
      end
    endcase
  endfunction

  // small values make ties, extremes hit saturation, the rest is full range
  function automatic logic signed [15:0] pick_signed(input int small_span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 2 * small_span)) - 16'(small_span);
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh8001;
        default: return 16'sh7ffe;
      endcase
    end
    return 16'($urandom);
  endfunction

  // offer one transaction after an optional gap and hold it until taken
  task automatic offer(input logic [1:0] o, input logic signed [15:0] p,
                       input logic [31:0] d, input logic signed [15:0] dl);
    int gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= o;
    new_priority <= p;
    new_data     <= d;
    delta        <= dl;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering until every result has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // receiver: random stalls, quiet stretches and requested long hold-offs
  initial begin
    int stall_len;
    int run_len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx   = 1'b0;
        stall_len = 400;
      end else begin
        stall_len = rx_quiet ? 0 : pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      run_len = rx_quiet ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (run_len) @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int sent;
    int phase;
    int mode;
    int n;
    int i;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_ENQ;
    new_priority = '0;
    new_data     = '0;
    delta        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue: peek, dequeue and change
    offer(OP_PEEK, 16'sh0000, 32'h0000_0000, 16'sh0000);
    offer(OP_DEQ, 16'sh7fff, 32'hffff_ffff, 16'sh8000);
    offer(OP_CHG, 16'sh8000, 32'h0000_0000, 16'sh7fff);
    // fill to capacity with extremes and ties, then one enqueue too many
    for (i = 0; i < 16; i++)
      offer(OP_ENQ, FILL_PRIO[i*16 +: 16],
            (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hffff_ffff : {16'ha5a5, 16'(i)},
            16'sh0000);
    offer(OP_ENQ, 16'sh1234, 32'h5a5a_5a5a, 16'sh0000);
    // saturate up and down
    offer(OP_PEEK, 16'sh0000, 32'h0000_0000, 16'sh0000);
    offer(OP_CHG, 16'sh0000, 32'h0000_0000, 16'sh7fff);
    offer(OP_DEQ, 16'sh0000, 32'h0000_0000, 16'sh0000);
    offer(OP_CHG, 16'sh0000, 32'h0000_0000, 16'sh8000);
    offer(OP_DEQ, 16'sh0000, 32'h0000_0000, 16'sh0000);
    wait_all_results();

    // random phases that swing the fill level between empty and full
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode     = phase % 4;
      in_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 3 || phase == 11) hold_rx = 1'b1;
      n = $urandom_range(40, 120);
      repeat (n) begin
        offer(pick_op(mode), pick_signed(4), $urandom, pick_signed(3));
        sent++;
      end
      if (phase % 3 == 2) wait_all_results();
      phase++;
    end

    // drain and let any stray result show up
    wait_all_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
